// ===== rtl/bbse_pkg.sv =====
// Package for the bicubic B-spline surface evaluator: command codes,
// fixed-point widths and the weight type. No dependencies.
package bbse_pkg;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_VALUE = 2'd1,
		CMD_DX    = 2'd2,
		CMD_DY    = 2'd3
	} cmd_t;

	localparam int REG_X_ORIGIN = 0;
	localparam int REG_Y_ORIGIN = 1;
	localparam int REG_X_SCALE  = 2;
	localparam int REG_Y_SCALE  = 3;
	localparam int REG_CELLS_X  = 4;
	localparam int REG_CELLS_Y  = 5;

	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 32;
	localparam int CoefIdxW = 12;
	localparam int AxisW = 6;

	typedef logic signed [31:0] q16_t;
	// Weight in Q2.30, magnitude below 2^32.
	typedef logic signed [33:0] wgt_t;

endpackage

// ===== rtl/bbse_if.sv =====
// Valid/ready channel interface carrying a payload of type T.
// Depends on nothing.
interface bbse_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/bbse_wgt.sv =====
// Weight former for one axis: cubic B-spline weights in Q2.30 from a Q0.16
// fraction, one weight a cycle through a shared multiply. Uses bbse_pkg.
module bbse_wgt (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [15:0]          frac,
	input  logic                 drv,
	output logic                 done,
	output bbse_pkg::wgt_t       w0,
	output bbse_pkg::wgt_t       w1,
	output bbse_pkg::wgt_t       w2,
	output bbse_pkg::wgt_t       w3
);
	import bbse_pkg::*;

	// Reciprocal of 3 scaled by 2^33; exact for every 32-bit dividend.
	localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

	// Powers at Q.48; t^3 needs 48 bits, numerators need 52 signed.
	logic [2:0]         step_q;
	logic               busy_q;
	logic [31:0]        t2_q;
	logic [47:0]        t3_q;
	logic signed [52:0] num;
	logic [52:0]        mag;
	logic [52:0]        rnd;
	logic [31:0]        ysh;
	logic [33:0]        quo;
	logic [63:0]        recip;
	logic signed [52:0] one48, t1, t2, t3;
	wgt_t               wv;

	assign one48 = 53'sd1 <<< 48;
	assign t1 = $signed({5'd0, frac, 32'd0});
	assign t2 = $signed({5'd0, t2_q, 16'd0});
	assign t3 = $signed({5'd0, t3_q});

	always_comb begin
		num = '0;
		case (step_q)
			3'd2: num = drv ? (-3 * one48 + 6 * t1 - 3 * t2) : (one48 - 3 * t1 + 3 * t2 - t3);
			3'd3: num = drv ? (-12 * t1 + 9 * t2) : (4 * one48 - 6 * t2 + 3 * t3);
			3'd4: num = drv ? (3 * one48 + 6 * t1 - 9 * t2) : (one48 + 3 * t1 + 3 * t2 - 3 * t3);
			3'd5: num = drv ? (3 * t2) : t3;
			default: num = '0;
		endcase
		mag = num[52] ? 53'(-num) : num;
		// Divide by 6*2^18: round, shift by 19, then divide by 3 with a reciprocal
		// multiply. The magnitude never exceeds 4*2^48, so the shifted value fits 32 bits.
		rnd = mag + 53'(3 << 18);
		ysh = 32'(rnd >> 19);
		recip = 64'(ysh) * 64'(RECIP3);
		quo = 34'(recip[63:33]);
		wv = num[52] ? -$signed(quo) : $signed(quo);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			busy_q <= 1'b0;
		end else if (start) begin
			step_q <= 3'd0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			step_q <= step_q + 3'd1;
			if (step_q == 3'd5) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && step_q == 3'd0) t2_q <= frac * frac;
		if (busy_q && step_q == 3'd1) t3_q <= t2_q * frac;
		if (busy_q) begin
			case (step_q)
				3'd2: w0 <= wv;
				3'd3: w1 <= wv;
				3'd4: w2 <= wv;
				3'd5: w3 <= wv;
				default: ;
			endcase
		end
	end

	assign done = busy_q && step_q == 3'd5;
endmodule

// ===== rtl/bicubic_bspline_surface_eval_top.sv =====
// Bicubic B-spline surface evaluator top level: locate, weights, 4x4 sum.
// Depends on bbse_pkg, bbse_if and bbse_wgt.
//
// Usage: items arrive on the in channel (cmd, coef_index, coef_value,
// x_coord, y_coord); one result item (value, inside_res) leaves on the out
// channel for each. A write stores one coefficient; its result passes
// through the ST_OUT state into the output register. An evaluation locates
// the point with the shared multiplier, x axis first and then y, forms the
// eight weights (the two axis units of 6 steps run side by side), makes the
// 16 store reads, one per cycle, with the multiply-accumulate and a row
// stage behind them, then rounds and saturates and loads the output
// register. The in channel is not ready while an item is at work, so a
// new item is taken only after the last has reached the output register.
// The result waits in the output register while the receiver stalls;
// the next item is accepted meanwhile and held until the register is
// free. Reset returns the registers to their defaults; the coefficient
// store holds nothing until written and needs no clearing.
module bicubic_bspline_surface_eval_top #(
	parameter int MAX_CELLS_X = 61,
	parameter int MAX_CELLS_Y = 61
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [bbse_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [bbse_pkg::CfgDataW-1:0] cfg_data,
	bbse_if.sink                      in_ch,
	bbse_if.source                    out_ch
);
	import bbse_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_LOC  = 6'b000010,
		ST_WGT  = 6'b000100,
		ST_ROW  = 6'b001000,
		ST_FIN  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	state_t state_q;
	logic signed [31:0] x_origin_q, y_origin_q;
	logic [31:0] x_scale_q, y_scale_q;
	logic [5:0] cells_x_q, cells_y_q;

	logic [1:0]  cmd_q;
	logic signed [31:0] xc_q, yc_q;
	logic        axis_q;
	logic [5:0]  ix_q, iy_q;
	logic [15:0] tx_q, ty_q;
	logic        inside_q;
	logic [4:0]  k_q;
	logic        rd_vld_q;
	logic [3:0]  rd_k_q;
	logic signed [31:0] coef_rd_q;
	logic signed [63:0] row_q, tot_q;
	logic signed [63:0] rowf_q;
	logic        rowf_vld_q;
	logic [1:0]  rowf_j_q;
	logic signed [31:0] res_q;
	logic signed [31:0] out_val_q;
	logic        out_ins_q, out_vld_q;

	logic [31:0] coef_mem [4096];

	// Locate multiplier: one axis per cycle.
	logic signed [32:0] d;
	logic [64:0] prod;
	logic [31:0] lim;
	logic [31:0] lim_x, lim_y;
	assign lim_x = (32'(cells_x_q) < 32'(MAX_CELLS_X)) ? 32'(cells_x_q) : 32'(MAX_CELLS_X);
	assign lim_y = (32'(cells_y_q) < 32'(MAX_CELLS_Y)) ? 32'(cells_y_q) : 32'(MAX_CELLS_Y);
	always_comb begin
		d = axis_q ? (33'(yc_q) - 33'(y_origin_q)) : (33'(xc_q) - 33'(x_origin_q));
		prod = 65'($unsigned(d[31:0])) * 65'(axis_q ? y_scale_q : x_scale_q);
		lim = axis_q ? lim_y : lim_x;
	end

	logic wstart, wxd, wyd, wdone_x, wdone_y;
	wgt_t wx0, wx1, wx2, wx3, wy0, wy1, wy2, wy3;
	bbse_wgt u_wx (.clk, .arst_n, .start(wstart), .frac(tx_q), .drv(cmd_q == CMD_DX),
		.done(wdone_x), .w0(wx0), .w1(wx1), .w2(wx2), .w3(wx3));
	bbse_wgt u_wy (.clk, .arst_n, .start(wstart), .frac(ty_q), .drv(cmd_q == CMD_DY),
		.done(wdone_y), .w0(wy0), .w1(wy1), .w2(wy2), .w3(wy3));
	assign wxd = wdone_x;
	assign wyd = wdone_y;

	// Rounding helper done inline: half away from zero by 30 bits.
	logic [11:0] rd_addr;
	assign rd_addr = {6'(iy_q + 6'(k_q[3:2])), 6'(ix_q + 6'(k_q[1:0]))};

	wgt_t wsel_x, wsel_y;
	always_comb begin
		case (rd_k_q[1:0])
			2'd0: wsel_x = wx0;
			2'd1: wsel_x = wx1;
			2'd2: wsel_x = wx2;
			default: wsel_x = wx3;
		endcase
		case (rowf_j_q)
			2'd0: wsel_y = wy0;
			2'd1: wsel_y = wy1;
			2'd2: wsel_y = wy2;
			default: wsel_y = wy3;
		endcase
	end

	// A finished row sum is registered first, then rounded and weighted by y
	// in the following cycle, so no cycle holds two multiplies in series.
	logic signed [65:0] term;
	logic signed [63:0] row_next, row_rnd, tot_rnd, tot_next;
	logic [63:0] rmag, tmag;
	always_comb begin
		term = 66'(coef_rd_q) * 66'(wsel_x);
		row_next = row_q + 64'(term);
		rmag = rowf_q[63] ? 64'(-rowf_q) : rowf_q;
		rmag = (rmag + 64'(1 << 29)) >> 30;
		row_rnd = rowf_q[63] ? -$signed(rmag) : $signed(rmag);
		tot_next = tot_q + 64'(row_rnd * 64'(wsel_y));
		tmag = tot_q[63] ? 64'(-tot_q) : tot_q;
		tmag = (tmag + 64'(1 << 29)) >> 30;
		tot_rnd = tot_q[63] ? -$signed(tmag) : $signed(tmag);
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = out_vld_q;
	assign out_ch.data.value = out_val_q;
	assign out_ch.data.inside_res = out_ins_q;
	assign wstart = (state_q == ST_LOC) && axis_q && inside_q
		&& !prod[64] && (prod[63:32] < lim) && !d[32];

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready && in_ch.data.cmd == CMD_WRITE)
			coef_mem[in_ch.data.coef_index] <= in_ch.data.coef_value;
		coef_rd_q <= coef_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			x_origin_q <= '0; y_origin_q <= '0;
			x_scale_q <= 32'd65536; y_scale_q <= 32'd65536;
			cells_x_q <= 6'd61; cells_y_q <= 6'd61;
			out_vld_q <= 1'b0;
			rd_vld_q <= 1'b0;
			rowf_vld_q <= 1'b0;
			k_q <= '0; axis_q <= 1'b0; inside_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					3'(REG_X_ORIGIN): x_origin_q <= cfg_data;
					3'(REG_Y_ORIGIN): y_origin_q <= cfg_data;
					3'(REG_X_SCALE):  x_scale_q <= cfg_data;
					3'(REG_Y_SCALE):  y_scale_q <= cfg_data;
					3'(REG_CELLS_X):  cells_x_q <= cfg_data[5:0];
					3'(REG_CELLS_Y):  cells_y_q <= cfg_data[5:0];
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) out_vld_q <= 1'b0;
			rd_vld_q <= 1'b0;
			rowf_vld_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						cmd_q <= in_ch.data.cmd;
						xc_q <= in_ch.data.x_coord;
						yc_q <= in_ch.data.y_coord;
						axis_q <= 1'b0;
						inside_q <= 1'b1;
						if (in_ch.data.cmd == CMD_WRITE) begin
							res_q <= '0;
							state_q <= ST_OUT;
						end else state_q <= ST_LOC;
					end
				end
				ST_LOC: begin
					if (d[32] || prod[64] || prod[63:32] >= lim) inside_q <= 1'b0;
					if (!axis_q) begin
						ix_q <= prod[37:32]; tx_q <= prod[31:16];
						axis_q <= 1'b1;
					end else begin
						iy_q <= prod[37:32]; ty_q <= prod[31:16];
						if (wstart) state_q <= ST_WGT;
						else begin
							inside_q <= 1'b0;
							res_q <= '0;
							state_q <= ST_OUT;
						end
					end
					if (!axis_q && (d[32] || prod[64] || prod[63:32] >= lim)) begin
						res_q <= '0;
						state_q <= ST_OUT;
					end
				end
				ST_WGT: begin
					k_q <= '0; row_q <= '0; tot_q <= '0;
					if (wxd && wyd) state_q <= ST_ROW;
				end
				ST_ROW: begin
					if (k_q != 5'd16) begin
						rd_vld_q <= 1'b1;
						rd_k_q <= k_q[3:0];
						k_q <= k_q + 5'd1;
					end
					if (rd_vld_q) begin
						if (rd_k_q[1:0] == 2'd3) begin
							row_q <= '0;
							rowf_q <= row_next;
							rowf_j_q <= rd_k_q[3:2];
							rowf_vld_q <= 1'b1;
						end else row_q <= row_next;
					end
					if (rowf_vld_q) begin
						tot_q <= tot_next;
						if (rowf_j_q == 2'd3) state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (tot_rnd > 64'sd2147483647) res_q <= 32'sh7fffffff;
					else if (tot_rnd < -64'sd2147483648) res_q <= 32'sh80000000;
					else res_q <= tot_rnd[31:0];
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_vld_q || out_ch.ready) begin
						out_vld_q <= 1'b1;
						out_val_q <= res_q;
						out_ins_q <= inside_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/bbse_chk.sv =====
// Port-level checker for the surface evaluator, bound to its top level.
// Depends on bbse_pkg, which it imports for the command codes.
module bbse_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic [1:0] in_cmd,
	input logic out_valid,
	input logic out_ready,
	input logic [31:0] out_value,
	input logic out_inside
);
	import bbse_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value)) else $error("result dropped");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("accepted while busy");
	// A write taken while the output register is empty answers straight away.
	a_wr: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_cmd == CMD_WRITE && !out_valid
		|=> ##1 out_valid && out_inside)
		else $error("write answer");
	a_out0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_inside |-> out_value == 32'd0) else $error("outside not zero");
endmodule

bind bicubic_bspline_surface_eval_top bbse_chk u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.in_cmd(in_ch.data.cmd), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_value(out_ch.data.value), .out_inside(out_ch.data.inside_res));

// ===== bench/bicubic_bspline_surface_eval_if_types.sv =====
// Item types for the surface evaluator bench: the input item and the result item.
// Depends on bbse_pkg; the channels themselves use bbse_if from the RTL.
package bbse_tb_types_pkg;
	import bbse_pkg::*;

	typedef struct packed {
		cmd_t                 cmd;
		logic [CoefIdxW-1:0]  coef_index;
		q16_t                 coef_value;
		q16_t                 x_coord;
		q16_t                 y_coord;
	} eval_req_t;

	typedef struct packed {
		q16_t value;
		logic inside_res;
	} eval_rsp_t;

endpackage

// ===== bench/bicubic_bspline_surface_eval_top_tb.sv =====
// Self-checking bench for the bicubic B-spline surface evaluator: a queue-fed driver,
// a monitor checking against an in-bench fixed-point predictor, several register phases.
// Depends on bbse_pkg, bbse_tb_types_pkg, bbse_if and the top level.
module bicubic_bspline_surface_eval_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bbse_pkg::*;
	import bbse_tb_types_pkg::*;

	localparam int  MAX_X = 61;
	localparam int  MAX_Y = 61;
	localparam int  CYCLE_LIMIT = 1000000;
	localparam int  DRAIN_CYCLES = 60;
	localparam longint ONE48 = 64'sd1 <<< 48;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	bbse_if #(.T(eval_req_t)) in_ch ();
	bbse_if #(.T(eval_rsp_t)) out_ch ();

	bicubic_bspline_surface_eval_top #(.MAX_CELLS_X(MAX_X), .MAX_CELLS_Y(MAX_Y)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// Register copies used by the predictor and the generator alike.
	logic signed [31:0] org_x, org_y;
	logic [31:0] scl_x, scl_y;
	logic [5:0]  ncell_x, ncell_y;

	logic [31:0] coef_shadow [0:4095];
	bit          gen_written [0:4095];

	eval_req_t pending_items [$];
	eval_rsp_t expected_results [$];

	int tx_idle_pct, rx_idle_pct;
	int errors, cycles;
	int n_writes, n_evals, n_inside, n_outside, n_results;

	function automatic int axis_limit(logic [5:0] ncell, int maxc);
		return (int'(ncell) < maxc) ? int'(ncell) : maxc;
	endfunction

	function automatic bit locate_axis(logic signed [31:0] coord, logic signed [31:0] origin,
			logic [31:0] scale, int lim, output int cell_no, output logic [15:0] frac);
		longint d;
		logic [63:0] prod;
		cell_no = 0;
		frac = '0;
		d = longint'(coord) - longint'(origin);
		if (d < 0)
			return 0;
		prod = 64'(d) * 64'(scale);
		if (prod[63:32] >= 64'(lim))
			return 0;
		cell_no = int'(prod[63:32]);
		frac = prod[31:16];
		return 1;
	endfunction

	function automatic longint round_half_away(longint v, int s);
		longint m;
		m = (v < 0) ? -v : v;
		m = (m + (64'sd1 <<< (s - 1))) >>> s;
		return (v < 0) ? -m : m;
	endfunction

	function automatic void axis_weights(logic [15:0] t, bit drv, output longint w [4]);
		longint tt, t1, t2, t3, m, q;
		longint n [4];
		longint den;
		den = 64'sd6 <<< 18;
		tt = longint'(t);
		t1 = tt <<< 32;
		t2 = (tt * tt) <<< 16;
		t3 = tt * tt * tt;
		if (drv) begin
			n[0] = -3 * ONE48 + 6 * t1 - 3 * t2;
			n[1] = -12 * t1 + 9 * t2;
			n[2] = 3 * ONE48 + 6 * t1 - 9 * t2;
			n[3] = 3 * t2;
		end else begin
			n[0] = ONE48 - 3 * t1 + 3 * t2 - t3;
			n[1] = 4 * ONE48 - 6 * t2 + 3 * t3;
			n[2] = ONE48 + 3 * t1 + 3 * t2 - 3 * t3;
			n[3] = t3;
		end
		for (int k = 0; k < 4; k++) begin
			m = (n[k] < 0) ? -n[k] : n[k];
			q = (m + den / 2) / den;
			w[k] = (n[k] < 0) ? -q : q;
		end
	endfunction

	function automatic eval_rsp_t surface_predict(eval_req_t it);
		eval_rsp_t r;
		int ix, iy;
		logic [15:0] tx, ty;
		longint wx [4], wy [4];
		longint row, total, res;
		logic [11:0] addr;
		r.value = '0;
		r.inside_res = 1'b1;
		if (it.cmd == CMD_WRITE) begin
			coef_shadow[it.coef_index] = it.coef_value;
			return r;
		end
		if (!locate_axis(it.x_coord, org_x, scl_x, axis_limit(ncell_x, MAX_X), ix, tx) ||
			!locate_axis(it.y_coord, org_y, scl_y, axis_limit(ncell_y, MAX_Y), iy, ty)) begin
			r.inside_res = 1'b0;
			return r;
		end
		axis_weights(tx, it.cmd == CMD_DX, wx);
		axis_weights(ty, it.cmd == CMD_DY, wy);
		total = 0;
		for (int j = 0; j < 4; j++) begin
			row = 0;
			for (int i = 0; i < 4; i++) begin
				addr = {6'(iy + j), 6'(ix + i)};
				row += longint'(signed'(coef_shadow[addr])) * wx[i];
			end
			total += round_half_away(row, 30) * wy[j];
		end
		res = round_half_away(total, 30);
		if (res > 64'sd2147483647)
			res = 64'sd2147483647;
		if (res < -64'sd2147483648)
			res = -64'sd2147483648;
		r.value = res[31:0];
		return r;
	endfunction

	function automatic logic [31:0] random_coef();
		if ($urandom_range(99) < 30)
			return $urandom;
		return 32'(int'($urandom_range(32'h0008_0000)) - 32'sh0004_0000);
	endfunction

	function automatic void queue_write(logic [11:0] idx, logic [31:0] val);
		eval_req_t it;
		it.cmd = CMD_WRITE;
		it.coef_index = idx;
		it.coef_value = val;
		it.x_coord = $urandom;
		it.y_coord = $urandom;
		gen_written[idx] = 1'b1;
		pending_items.push_back(it);
	endfunction

	// Evaluations only ever read coefficients that have been written, so any
	// missing entry of the 4x4 block is written first with random content.
	function automatic void queue_eval(cmd_t c, logic [31:0] x, logic [31:0] y);
		eval_req_t it;
		int ix, iy;
		logic [15:0] tx, ty;
		logic [11:0] addr;
		if (locate_axis(x, org_x, scl_x, axis_limit(ncell_x, MAX_X), ix, tx) &&
			locate_axis(y, org_y, scl_y, axis_limit(ncell_y, MAX_Y), iy, ty)) begin
			for (int j = 0; j < 4; j++)
				for (int i = 0; i < 4; i++) begin
					addr = {6'(iy + j), 6'(ix + i)};
					if (!gen_written[addr])
						queue_write(addr, random_coef());
				end
		end
		it.cmd = c;
		it.coef_index = $urandom;
		it.coef_value = $urandom;
		it.x_coord = x;
		it.y_coord = y;
		pending_items.push_back(it);
	endfunction

	// A coordinate aimed at a chosen cell, mostly one of the first few, sometimes
	// the last cell or one just past the end.
	function automatic logic [31:0] aim_coord(logic [31:0] origin, logic [31:0] scale, int lim);
		int cell_no;
		logic [63:0] off;
		int sel;
		sel = $urandom_range(99);
		if (lim == 0 || sel < 5)
			return $urandom;
		if (sel < 12)
			cell_no = lim - 1;
		else if (sel < 17)
			cell_no = lim;
		else
			cell_no = $urandom_range((lim < 6 ? lim : 6) - 1);
		off = {32'(cell_no), 32'h0} + 64'($urandom);
		return origin + 32'(off / 64'(scale));
	endfunction

	task automatic write_reg(int idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CfgIdxW'(idx);
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_X_ORIGIN: org_x = val;
			REG_Y_ORIGIN: org_y = val;
			REG_X_SCALE:  scl_x = val;
			REG_Y_SCALE:  scl_y = val;
			REG_CELLS_X:  ncell_x = val[5:0];
			REG_CELLS_Y:  ncell_y = val[5:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Driver: takes pending items in order, holding each until it is accepted.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				expected_results.push_back(surface_predict(in_ch.data));
				if (in_ch.data.cmd == CMD_WRITE)
					n_writes++;
				else
					n_evals++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					in_ch.valid <= 1'b1;
					in_ch.data <= pending_items.pop_front();
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: every accepted result against the oldest expectation.
	always @(posedge clk) begin
		eval_rsp_t exp_r;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				n_results++;
				if (expected_results.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("Unexpected result item: value %h inside %b",
							out_ch.data.value, out_ch.data.inside_res);
				end else begin
					exp_r = expected_results.pop_front();
					if (exp_r.inside_res)
						n_inside++;
					else
						n_outside++;
					if (out_ch.data.value !== exp_r.value ||
						out_ch.data.inside_res !== exp_r.inside_res) begin
						errors++;
						if (errors <= 10)
							$display("Mismatch at %0t: value %h/%h inside %b/%b (exp/got)",
								$realtime, exp_r.value, out_ch.data.value,
								exp_r.inside_res, out_ch.data.inside_res);
					end
				end
			end
			out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	initial begin
		logic [31:0] ph_cfg [5][6];
		int ph_items;
		cmd_t c;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		errors = 0;
		cycles = 0;
		n_writes = 0;
		n_evals = 0;
		n_inside = 0;
		n_outside = 0;
		n_results = 0;
		tx_idle_pct = 16;
		rx_idle_pct = 80;
		org_x = 0;
		org_y = 0;
		scl_x = 32'h0001_0000;
		scl_y = 32'h0001_0000;
		ncell_x = 6'd61;
		ncell_y = 6'd61;
		for (int k = 0; k < 4096; k++) begin
			coef_shadow[k] = '0;
			gen_written[k] = 1'b0;
		end

		// Register settings per phase: x_origin, y_origin, x_scale, y_scale, cells.
		ph_cfg[0] = '{32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'd61, 32'd61};
		ph_cfg[1] = '{32'hFFFB_0000, 32'h0003_0000, 32'h0000_8000, 32'h0002_0000,
			32'd7, 32'd4};
		ph_cfg[2] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001,
			32'd1, 32'd61};
		ph_cfg[3] = '{32'h7FFF_0000, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
			32'd63, 32'd0};
		ph_cfg[4] = '{32'hFFFF_C000, 32'h0000_4000, 32'h0003_3333, 32'h0000_2000,
			32'd12, 32'd63};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed items with the reset settings: extremes of the store, both
		// borders of the domain and every command.
		queue_write(12'd0, 32'h7FFF_FFFF);
		queue_write(12'd4095, 32'h8000_0000);
		queue_write(12'd1, 32'h8000_0000);
		queue_write(12'd64, 32'h7FFF_FFFF);
		queue_eval(CMD_VALUE, 32'h0, 32'h0);
		queue_eval(CMD_DX, 32'h0, 32'h0);
		queue_eval(CMD_DY, 32'h0, 32'h0);
		queue_eval(CMD_VALUE, 32'h0000_8000, 32'h0000_4000);
		queue_eval(CMD_DX, 32'h0000_FFFF, 32'h0000_C000);
		queue_eval(CMD_DY, 32'h0001_7FFF, 32'h0000_0001);
		queue_eval(CMD_VALUE, 32'hFFFF_FFFF, 32'h0);
		queue_eval(CMD_VALUE, 32'h0, 32'hFFFF_FFFF);
		queue_eval(CMD_DX, 32'h003D_0000, 32'h0);
		queue_eval(CMD_DY, 32'h0, 32'h003D_0000);
		queue_eval(CMD_VALUE, 32'h003C_FFFF, 32'h003C_FFFF);
		queue_eval(CMD_VALUE, 32'h7FFF_FFFF, 32'h8000_0000);
		queue_eval(CMD_DX, 32'h8000_0000, 32'h7FFF_FFFF);

		for (int ph = 0; ph < 5; ph++) begin
			if (ph == 2) begin
				tx_idle_pct = 80;
				rx_idle_pct = 16;
			end else if (ph == 4) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			if (ph != 0) begin
				drain();
				for (int r = 0; r < 6; r++)
					write_reg(r, ph_cfg[ph][r]);
			end
			ph_items = 0;
			while (ph_items < 50) begin
				if ($urandom_range(99) < 20) begin
					queue_write(12'($urandom), random_coef());
				end else begin
					c = cmd_t'($urandom_range(int'(CMD_VALUE), int'(CMD_DY)));
					if ($urandom_range(99) < 15)
						queue_eval(c, $urandom, $urandom);
					else
						queue_eval(c, aim_coord(org_x, scl_x, axis_limit(ncell_x, MAX_X)),
							aim_coord(org_y, scl_y, axis_limit(ncell_y, MAX_Y)));
				end
				ph_items++;
				// Let the driver catch up so the queue never grows large.
				while (pending_items.size() > 20)
					@(posedge clk);
			end
		end
		drain();

		$display("Covered %0d coefficient writes and %0d evaluations over five register settings,",
			n_writes, n_evals);
		$display("%0d results checked: %0d with inside set (writes included), %0d outside the domain",
			n_results, n_inside, n_outside);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches", errors);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/bbse_pkg.sv
rtl/bbse_if.sv
rtl/bbse_wgt.sv
rtl/bicubic_bspline_surface_eval_top.sv
rtl/bbse_chk.sv
bench/bicubic_bspline_surface_eval_if_types.sv
bench/bicubic_bspline_surface_eval_top_tb.sv
